// File: rtl/kh_pkg.sv
// Package: constants, bus types and mix helper functions for the key hash scrambler.
`default_nettype none
package kh_pkg;

    localparam int LENGTH_BITS = 32;
    localparam int KEY_LEN_W   = 32;
    localparam int LEN_W       = (LENGTH_BITS < KEY_LEN_W) ? LENGTH_BITS : KEY_LEN_W;

    localparam logic [63:0] K0  = 64'ha0761d6478bd642f;
    localparam logic [63:0] K1  = 64'he7037ed1a0b428db;
    localparam logic [63:0] K2  = 64'h8ebc6af09c88c6e3;
    localparam logic [63:0] K3  = 64'h589965cc75374cc3;
    localparam logic [63:0] K4  = 64'h1d8e4e27c47d124f;
    localparam logic [63:0] AV1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] AV2 = 64'h94d049bb133111eb;
    localparam logic [63:0] RF1 = 64'h2127599bf4325c37;

    localparam logic [7:0] PREFIX_PLAIN = 8'h68;
    localparam logic [7:0] PREFIX_SHUF  = 8'h73;

    localparam logic [1:0] CFG_SHUFFLE = 2'd0;
    localparam logic [1:0] CFG_SEED    = 2'd1;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic         done;
        logic [127:0] prod;
    } mul_rsp_t;

    function automatic logic [63:0] round_const(input logic [1:0] idx);
        logic [63:0] c;
        case (idx)
            2'd0:    c = K0;
            2'd1:    c = K1;
            2'd2:    c = K2;
            default: c = K3;
        endcase
        return c;
    endfunction

    // xor-fold of a 128-bit product
    function automatic logic [63:0] fold(input logic [127:0] p);
        return p[63:0] ^ p[127:64];
    endfunction

    // round function input side, before the multiply
    function automatic logic [63:0] round_pre(input logic [31:0] half, input logic [63:0] rk);
        logic [63:0] x;
        x = {32'b0, half} ^ rk;
        x = x ^ (x >> 23);
        return x;
    endfunction

    // round function output side, after the multiply
    function automatic logic [31:0] round_post(input logic [63:0] p);
        logic [63:0] x;
        x = p ^ (p >> 47);
        return x[31:0] ^ x[63:32];
    endfunction

endpackage
`default_nettype wire

// File: rtl/kh_mul.sv
// Iterative 64x64->128 multiplier built on one 32x32 multiplier, one partial product a cycle.
`default_nettype none
module kh_mul (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire kh_pkg::mul_req_t req,
    output kh_pkg::mul_rsp_t   rsp
);

    logic         busy_reg;
    logic         done_reg;
    logic [2:0]   cnt_reg;
    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [63:0]  pp_reg;
    logic [127:0] acc_reg;

    logic [1:0]   step;
    logic [1:0]   prev_step;
    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [127:0] pp_shifted;

    assign step      = cnt_reg[1:0];
    assign prev_step = 2'(cnt_reg - 3'd1);
    assign a_half    = step[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_half    = step[0] ? b_reg[63:32] : b_reg[31:0];

    always_comb
    begin
        case (prev_step)
            2'd0:    pp_shifted = {64'b0, pp_reg};
            2'd3:    pp_shifted = {pp_reg, 64'b0};
            default: pp_shifted = {32'b0, pp_reg, 32'b0};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 3'd1;
            if (cnt_reg == 3'd4)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != 3'd4)
                pp_reg <= 64'(a_half) * 64'(b_half);
            if (cnt_reg != 3'd0)
                acc_reg <= acc_reg + pp_shifted;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule
`default_nettype wire

// File: rtl/key_hash_feistel_scramble_core.sv
// Top level: word sequencer, hash state, avalanche and Feistel rounds on a shared multiplier.
// Each 64-bit product is built from 4 partial products on the single 32x32 multiplier.
// Non-final word: key_stall stays high while its mix is computed, so no new word is taken
// meanwhile. Final word: mixes, avalanche, Feistel rounds when shuffling, then the output.
// key_stall is high while a word is in work; a result may wait in the output register.
// Reset (rst_n, asynchronous, active low) clears the hash state, FSM state, length, open flag, config and valid.
`default_nettype none
module key_hash_feistel_scramble_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        key_valid,
    output logic             key_stall,
    input  wire logic [63:0] key_word,
    input  wire logic [3:0]  valid_bytes,
    input  wire logic        first_word,
    input  wire logic        last_word,
    input  wire logic [31:0] key_length,
    output logic             res_valid,
    input  wire logic        res_stall,
    output logic [7:0]       key_prefix,
    output logic [63:0]      key_value,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MIX1 = 3'd1;
    localparam logic [2:0] ST_MIX2 = 3'd2;
    localparam logic [2:0] ST_AV1  = 3'd3;
    localparam logic [2:0] ST_AV2  = 3'd4;
    localparam logic [2:0] ST_RND  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0]              state_reg, state_next;
    logic [63:0]             h_reg, h_next;
    logic [kh_pkg::LEN_W-1:0] len_reg, len_next;
    logic                    open_reg, open_next;
    logic                    last_reg, last_next;
    logic [63:0]             tail_reg, tail_next;
    logic [63:0]             v_reg, v_next;
    logic [1:0]              round_reg, round_next;
    logic                    res_valid_reg, res_valid_next;
    logic [7:0]              prefix_reg, prefix_next;
    logic [63:0]             value_reg, value_next;
    logic                    shuffle_reg;
    logic [63:0]             seed_reg;

    kh_pkg::mul_req_t mul_req;
    kh_pkg::mul_rsp_t mul_rsp;

    logic [63:0] word_m;
    logic        full;
    logic [63:0] h_start;
    logic [63:0] hmix;
    logic [63:0] len_ext;
    logic [63:0] vt;
    logic [31:0] nr;

    kh_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    always_comb
    begin
        for (int i = 0; i < 8; i++)
            word_m[i*8 +: 8] = (4'(i) < valid_bytes) ? key_word[i*8 +: 8] : 8'h00;
    end

    assign full    = (valid_bytes >= 4'd8);
    assign len_ext = 64'(len_reg);
    assign h_start = first_word ? (kh_pkg::K0 ^ 64'(key_length[kh_pkg::LEN_W-1:0])) : h_reg;
    assign hmix    = kh_pkg::fold(mul_rsp.prod);

    always_comb
    begin
        state_next     = state_reg;
        h_next         = h_reg;
        len_next       = len_reg;
        open_next      = open_reg;
        last_next      = last_reg;
        tail_next      = tail_reg;
        v_next         = v_reg;
        round_next     = round_reg;
        res_valid_next = res_valid_reg && res_stall;
        prefix_next    = prefix_reg;
        value_next     = value_reg;
        mul_req.start  = 1'b0;
        mul_req.a      = '0;
        mul_req.b      = '0;
        vt             = '0;
        nr             = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (key_valid && (first_word || open_reg))
                begin
                    if (first_word)
                    begin
                        len_next  = key_length[kh_pkg::LEN_W-1:0];
                        open_next = 1'b1;
                    end
                    h_next        = h_start;
                    last_next     = last_word;
                    tail_next     = (last_word && !full) ? word_m : 64'b0;
                    mul_req.start = 1'b1;
                    if (!last_word || full)
                    begin
                        mul_req.a  = word_m ^ kh_pkg::K1;
                        mul_req.b  = h_start ^ kh_pkg::K2;
                        state_next = ST_MIX1;
                    end
                    else
                    begin
                        mul_req.a  = word_m ^ kh_pkg::K3;
                        mul_req.b  = h_start ^ kh_pkg::K4;
                        state_next = ST_MIX2;
                    end
                end
            end
            ST_MIX1:
            begin
                if (mul_rsp.done)
                begin
                    h_next = hmix;
                    if (!last_reg)
                        state_next = ST_IDLE;
                    else
                    begin
                        mul_req.start = 1'b1;
                        mul_req.a     = tail_reg ^ kh_pkg::K3;
                        mul_req.b     = hmix ^ kh_pkg::K4;
                        state_next    = ST_MIX2;
                    end
                end
            end
            ST_MIX2:
            begin
                if (mul_rsp.done)
                begin
                    h_next        = hmix;
                    open_next     = 1'b0;
                    vt            = hmix ^ len_ext;
                    mul_req.start = 1'b1;
                    mul_req.a     = vt ^ (vt >> 30);
                    mul_req.b     = kh_pkg::AV1;
                    state_next    = ST_AV1;
                end
            end
            ST_AV1:
            begin
                if (mul_rsp.done)
                begin
                    vt            = mul_rsp.prod[63:0];
                    mul_req.start = 1'b1;
                    mul_req.a     = vt ^ (vt >> 27);
                    mul_req.b     = kh_pkg::AV2;
                    state_next    = ST_AV2;
                end
            end
            ST_AV2:
            begin
                if (mul_rsp.done)
                begin
                    vt     = mul_rsp.prod[63:0];
                    vt     = vt ^ (vt >> 31);
                    v_next = vt;
                    if (shuffle_reg)
                    begin
                        round_next    = 2'd0;
                        mul_req.start = 1'b1;
                        mul_req.a     = kh_pkg::round_pre(vt[31:0],
                                            seed_reg ^ kh_pkg::round_const(2'd0));
                        mul_req.b     = kh_pkg::RF1;
                        state_next    = ST_RND;
                    end
                    else
                        state_next = ST_DONE;
                end
            end
            ST_RND:
            begin
                if (mul_rsp.done)
                begin
                    nr     = v_reg[63:32] ^ kh_pkg::round_post(mul_rsp.prod[63:0]);
                    v_next = {v_reg[31:0], nr};
                    if (round_reg == 2'd3)
                        state_next = ST_DONE;
                    else
                    begin
                        round_next    = round_reg + 2'd1;
                        mul_req.start = 1'b1;
                        mul_req.a     = kh_pkg::round_pre(nr,
                                            seed_reg ^ kh_pkg::round_const(round_reg + 2'd1));
                        mul_req.b     = kh_pkg::RF1;
                    end
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next = 1'b1;
                    value_next     = v_reg;
                    prefix_next    = shuffle_reg ? kh_pkg::PREFIX_SHUF : kh_pkg::PREFIX_PLAIN;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            h_reg         <= '0;
            len_reg       <= '0;
            open_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            shuffle_reg   <= 1'b0;
            seed_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            h_reg         <= h_next;
            len_reg       <= len_next;
            open_reg      <= open_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == kh_pkg::CFG_SHUFFLE)
                    shuffle_reg <= cfg_data[0];
                else if (cfg_index == kh_pkg::CFG_SEED)
                    seed_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg   <= last_next;
        tail_reg   <= tail_next;
        v_reg      <= v_next;
        round_reg  <= round_next;
        prefix_reg <= prefix_next;
        value_reg  <= value_next;
    end

    assign key_stall  = (state_reg != ST_IDLE);
    assign res_valid  = res_valid_reg;
    assign key_prefix = prefix_reg;
    assign key_value  = value_reg;
    assign cfg_ready  = 1'b1;

    a_res_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the output state");

    a_done_in_mul_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> (state_reg == ST_MIX1 || state_reg == ST_MIX2 ||
                          state_reg == ST_AV1 || state_reg == ST_AV2 || state_reg == ST_RND))
        else $error("multiplier finished with no product pending");

    a_close_on_tail: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(open_reg) |-> $past(state_reg == ST_MIX2))
        else $error("key closed outside the tail mix");

    a_rounds_need_shuffle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RND) |-> shuffle_reg)
        else $error("Feistel rounds with shuffling off");

endmodule
`default_nettype wire
